// ----- sv/utd_pkg.sv -----
// ----------------------------------------------------------------------------
// utd_pkg: shared types and constants for the UTF-8 to UCS-2 decoder
// Lead byte prefixes, payload masks, decoder state and result structs.
// ----------------------------------------------------------------------------
package utd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 16;
    localparam int COUNT_W = 16;
    localparam int LEFT_W  = 3;
    localparam int LEN_W   = 3;

    // Lead byte prefixes, longest first
    localparam logic [BYTE_W-1:0] PREFIX_LEN6 = 8'hFC;
    localparam logic [BYTE_W-1:0] PREFIX_LEN5 = 8'hF8;
    localparam logic [BYTE_W-1:0] PREFIX_LEN4 = 8'hF0;
    localparam logic [BYTE_W-1:0] PREFIX_LEN3 = 8'hE0;
    localparam logic [BYTE_W-1:0] PREFIX_LEN2 = 8'hC0;

    localparam logic [BYTE_W-1:0] PAYLOAD_ALL = 8'hFF;
    localparam logic [BYTE_W-1:0] TERMINATOR  = 8'h00;
    localparam int                CONT_BITS   = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    // Decoder state carried between beats
    typedef struct packed {
        logic [LEFT_W-1:0]  bytes_left;
        logic [CODE_W-1:0]  accumulator;
        logic [COUNT_W-1:0] decoded_count;
    } utd_state_t;

    // Result produced by one input beat
    typedef struct packed {
        logic               valid;
        logic [CODE_W-1:0]  code_unit;
        logic [COUNT_W-1:0] char_count;
        logic               end_of_string;
    } utd_result_t;

    // Sequence length from the lead byte prefix
    function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        if ((b & PREFIX_LEN6) == PREFIX_LEN6)      len = 3'd6;
        else if ((b & PREFIX_LEN5) == PREFIX_LEN5) len = 3'd5;
        else if ((b & PREFIX_LEN4) == PREFIX_LEN4) len = 3'd4;
        else if ((b & PREFIX_LEN3) == PREFIX_LEN3) len = 3'd3;
        else if ((b & PREFIX_LEN2) == PREFIX_LEN2) len = 3'd2;
        else                                       len = 3'd1;
        return len;
    endfunction

endpackage

// ----- sv/utd_step.sv -----
// ----------------------------------------------------------------------------
// utd_step: one-beat decode step
// Combinational next state and result for one byte given the current state.
// ----------------------------------------------------------------------------
module utd_step (
    input  utd_pkg::utd_state_t              state_cur,
    input  logic [utd_pkg::BYTE_W-1:0]       in_byte,
    output utd_pkg::utd_state_t              state_next,
    output utd_pkg::utd_result_t             result
);

    logic [utd_pkg::LEN_W-1:0]   len;
    logic [utd_pkg::BYTE_W-1:0]  payload;
    logic [utd_pkg::COUNT_W-1:0] count_inc;

    // Lead byte decode
    assign len       = utd_pkg::lead_length(in_byte);
    assign payload   = in_byte & (utd_pkg::PAYLOAD_ALL >> len);
    // Saturating character count
    assign count_inc = (state_cur.decoded_count == utd_pkg::COUNT_MAX)
                     ? state_cur.decoded_count
                     : state_cur.decoded_count + 1'b1;

    // Next state and result
    always_comb begin
        state_next           = state_cur;
        result.valid         = 1'b0;
        result.code_unit     = '0;
        result.char_count    = state_cur.decoded_count;
        result.end_of_string = 1'b0;

        if (state_cur.bytes_left != '0) begin
            // Continuation: shift in six bits, no checking of the tag bits
            state_next.accumulator = {state_cur.accumulator[utd_pkg::CODE_W-utd_pkg::CONT_BITS-1:0],
                                      in_byte[utd_pkg::CONT_BITS-1:0]};
            state_next.bytes_left  = state_cur.bytes_left - 1'b1;
            if (state_cur.bytes_left == utd_pkg::LEFT_W'(1)) begin
                state_next.decoded_count = count_inc;
                result.valid             = 1'b1;
                result.code_unit         = state_next.accumulator;
                result.char_count        = count_inc;
            end
        end else if (in_byte == utd_pkg::TERMINATOR) begin
            // Terminator: report count, then clear
            result.valid             = 1'b1;
            result.end_of_string     = 1'b1;
            state_next.decoded_count = '0;
            state_next.accumulator   = '0;
        end else begin
            // Lead byte
            state_next.accumulator = {{(utd_pkg::CODE_W-utd_pkg::BYTE_W){1'b0}}, payload};
            state_next.bytes_left  = len - 1'b1;
            if (len == utd_pkg::LEN_W'(1)) begin
                state_next.decoded_count = count_inc;
                result.valid             = 1'b1;
                result.code_unit         = state_next.accumulator;
                result.char_count        = count_inc;
            end
        end
    end

endmodule

// ----- sv/utf8_to_ucs2_decoder_top.sv -----
// ----------------------------------------------------------------------------
// Output: a result beat is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the decode step is a single pass from the
// state registers to the result register, and s_ready stays high while the
// result register is empty or being drained by m_ready.
// Reset: synchronous, active-low aresetn clears decoder state and m_valid.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_top: byte-serial UTF-8 decoder with 16-bit code units
// Emits one beat per completed character and one end beat per terminator.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [utd_pkg::BYTE_W-1:0]      s_in_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [utd_pkg::CODE_W-1:0]      m_code_unit,
    output logic [utd_pkg::COUNT_W-1:0]     m_char_count,
    output logic                            m_end_of_string
);

    utd_pkg::utd_state_t  state_reg, state_next;
    utd_pkg::utd_result_t step_res;
    logic                 s_fire;
    logic                 m_valid_reg, m_valid_next;
    logic [utd_pkg::CODE_W-1:0]  code_unit_reg;
    logic [utd_pkg::COUNT_W-1:0] char_count_reg;
    logic                 eos_reg;

    // Handshake
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    utd_step u_step (
        .state_cur  (state_reg),
        .in_byte    (s_in_byte),
        .state_next (state_next),
        .result     (step_res)
    );

    // Decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register valid
    always_comb begin
        if (s_fire && step_res.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_fire && step_res.valid) begin
            code_unit_reg  <= step_res.code_unit;
            char_count_reg <= step_res.char_count;
            eos_reg        <= step_res.end_of_string;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_code_unit     = code_unit_reg;
    assign m_char_count    = char_count_reg;
    assign m_end_of_string = eos_reg;

    // Checks
    a_eos_zero_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_string) |-> (m_code_unit == '0))
        else $error("end beat with nonzero code unit");

    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && step_res.end_of_string) |=> (state_reg.decoded_count == '0))
        else $error("count not cleared after terminator");

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.bytes_left != 3'd6) && (state_reg.bytes_left != 3'd7))
        else $error("continuation count out of range");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

endmodule
